// ===== src/sms_pdu_sender_number_extract_core_assert.svh =====
// Assertion macros shared by the sender-number extractor RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SMS_PDU_SENDER_NUMBER_EXTRACT_CORE_ASSERT_SVH
`define SMS_PDU_SENDER_NUMBER_EXTRACT_CORE_ASSERT_SVH

// Property must hold at every sampled edge.
`define SMSNE_AST_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define SMSNE_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SMSNE_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/smsne_pkg.sv =====
// Types and constants for the SMS PDU sender-number extractor.
// No dependencies; imported by every module of the block.
package smsne_pkg;

  localparam int MAX_DIGITS = 32;

  localparam logic [7:0] HDR_BYTE  = 8'h11;
  localparam logic [7:0] INTL_TYPE = 8'h91;
  localparam logic [7:0] TYPE_MASK = 8'h03;
  localparam logic [5:0] CH_ZERO   = 6'd48;
  localparam logic [5:0] CH_PLUS   = 6'd43;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] ch;
    logic       last;
  } result_t;

  // Up to three results caused by one PDU byte, entry 0 first.
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     ent;
  } res_grp_t;

  function automatic result_t mk_result(logic [1:0] kind, logic [5:0] ch, logic last);
    result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.last = last;
    return r;
  endfunction

endpackage

// ===== src/smsne_parse.sv =====
// PDU header parser and digit decoder with its phase and counter registers.
// Depends on smsne_pkg and the assertion macro header.
`include "sms_pdu_sender_number_extract_core_assert.svh"

module smsne_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          pdu_byte,
  input  logic                pdu_start,
  output smsne_pkg::res_grp_t res_o
);
  import smsne_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SECOND = 4'd1;
  localparam logic [3:0] PH_THIRD  = 4'd2;
  localparam logic [3:0] PH_SCALEN = 4'd3;
  localparam logic [3:0] PH_SKIP   = 4'd4;
  localparam logic [3:0] PH_TYPE   = 4'd5;
  localparam logic [3:0] PH_COUNT  = 4'd6;
  localparam logic [3:0] PH_ATYPE  = 4'd7;
  localparam logic [3:0] PH_DIGITS = 4'd8;

  logic [3:0] phase_r, phase_nxt;
  logic [7:0] skip_r, skip_nxt;
  logic [5:0] want_r, want_nxt;
  logic [5:0] done_r, done_nxt;

  logic [5:0] d1, d2;
  logic       two, fin;
  result_t    r_end, r_rej;

  assign r_end = mk_result(KIND_END, 6'd0, 1'b1);
  assign r_rej = mk_result(KIND_REJECT, 6'd0, 1'b1);

  // Digit bookkeeping: low nibble always, high nibble while count allows.
  assign d1  = done_r + 6'd1;
  assign two = (d1 < want_r);
  assign d2  = two ? (d1 + 6'd1) : d1;
  assign fin = (d2 >= want_r);

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    want_nxt  = want_r;
    done_nxt  = done_r;
    res_o     = '0;
    if (step_en) begin
      if (pdu_start) begin
        skip_nxt = 8'd0;
        want_nxt = 6'd0;
        done_nxt = 6'd0;
        if (pdu_byte != HDR_BYTE) begin
          phase_nxt     = PH_IDLE;
          res_o.ent[0]  = r_rej;
          res_o.cnt     = 2'd1;
        end else begin
          phase_nxt = PH_SECOND;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            phase_nxt = PH_IDLE;
          end
          PH_SECOND: begin
            if (pdu_byte != HDR_BYTE) begin
              phase_nxt    = PH_IDLE;
              res_o.ent[0] = r_rej;
              res_o.cnt    = 2'd1;
            end else begin
              phase_nxt = PH_THIRD;
            end
          end
          PH_THIRD: begin
            if (pdu_byte == 8'd0) begin
              phase_nxt    = PH_IDLE;
              res_o.ent[0] = r_rej;
              res_o.cnt    = 2'd1;
            end else begin
              phase_nxt = PH_SCALEN;
            end
          end
          PH_SCALEN: begin
            skip_nxt  = pdu_byte;
            phase_nxt = (pdu_byte == 8'd0) ? PH_TYPE : PH_SKIP;
          end
          PH_SKIP: begin
            skip_nxt = skip_r - 8'd1;
            if (skip_r == 8'd1) begin
              phase_nxt = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if ((pdu_byte & TYPE_MASK) != 8'd0) begin
              phase_nxt    = PH_IDLE;
              res_o.ent[0] = r_rej;
              res_o.cnt    = 2'd1;
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            want_nxt  = (pdu_byte > 8'(MAX_DIGITS)) ? 6'(MAX_DIGITS) : pdu_byte[5:0];
            done_nxt  = 6'd0;
            phase_nxt = PH_ATYPE;
          end
          PH_ATYPE: begin
            if (pdu_byte == INTL_TYPE) begin
              res_o.ent[0] = mk_result(KIND_CHAR, CH_PLUS, 1'b0);
              if (want_r == 6'd0) begin
                res_o.ent[1] = r_end;
                res_o.cnt    = 2'd2;
              end else begin
                res_o.cnt = 2'd1;
              end
            end else if (want_r == 6'd0) begin
              res_o.ent[0] = r_end;
              res_o.cnt    = 2'd1;
            end
            phase_nxt = (want_r == 6'd0) ? PH_IDLE : PH_DIGITS;
          end
          PH_DIGITS: begin
            res_o.ent[0] = mk_result(KIND_CHAR, CH_ZERO + {2'b00, pdu_byte[3:0]}, 1'b0);
            if (two) begin
              res_o.ent[1] = mk_result(KIND_CHAR, CH_ZERO + {2'b00, pdu_byte[7:4]}, 1'b0);
            end
            if (fin) begin
              if (two) begin
                res_o.ent[2] = r_end;
              end else begin
                res_o.ent[1] = r_end;
              end
              phase_nxt = PH_IDLE;
            end
            res_o.cnt = 2'd1 + {1'b0, two} + {1'b0, fin};
            done_nxt  = d2;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      skip_r  <= 8'd0;
      want_r  <= 6'd0;
      done_r  <= 6'd0;
    end else begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      want_r  <= want_nxt;
      done_r  <= done_nxt;
    end
  end

  `SMSNE_AST_IMP(a_digits_pending, phase_r == PH_DIGITS, done_r < want_r, "digit phase with nothing left")
  `SMSNE_AST_IMP(a_three_ends, res_o.cnt == 2'd3, res_o.ent[2].last && res_o.ent[2].kind == KIND_END, "three results without closing end")
  `SMSNE_AST_IMP(a_skip_live, phase_r == PH_SKIP, skip_r != 8'd0, "skip phase with zero count")

endmodule

// ===== src/smsne_obuf.sv =====
// Result register and serializer: holds up to three results and drains one per transaction.
// Depends on smsne_pkg and the assertion macro header.
`include "sms_pdu_sender_number_extract_core_assert.svh"

module smsne_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  smsne_pkg::res_grp_t res_i,
  output logic                free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output smsne_pkg::result_t  out_res
);
  import smsne_pkg::*;

  logic [1:0]    cnt_r;
  result_t [2:0] ent_r;
  logic          pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_res    = ent_r[0];
  assign pop        = out_tvalid && out_tready;
  // Room for a new group once the last held result goes this cycle.
  assign free       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res_i.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= res_i.ent;
    end else if (pop) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

  `SMSNE_AST_IMP(a_last_is_final, out_tvalid && out_res.last, cnt_r == 2'd1, "closing result not last held")
  `SMSNE_AST_IMP(a_load_when_free, load, free, "group loaded over pending results")
  `SMSNE_AST_NXT(a_stall_hold, out_tvalid && !out_tready, $stable(out_res), "result moved in stall")

endmodule

// ===== src/sms_pdu_sender_number_extract_core.sv =====
// Top level of the SMS PDU sender-number extractor: input register, parser, result buffer.
// Depends on smsne_pkg, smsne_parse, smsne_obuf and the assertion macro header.
//
//   channel | direction | tdata            | tuser         | tlast
//   --------+-----------+------------------+---------------+---------
//   in_     | slave     | pdu_byte [7:0]   | pdu_start [0] | -
//   out_    | master    | out_char [5:0]   | out_kind[1:0] | out_last
//
// One PDU byte is taken per cycle while the result buffer has room; a byte is held in
// the input register, is parsed, and its results (zero to three) land together in the
// result buffer. The result port moves one result per transaction, so bytes that give
// several results hold the input side until they drain; the buffer drain sets the rate.
// Reset (rst_n low, synchronous) returns the parser to idle and empties both registers.
// Stalls on out_tready back up through the buffer to in_tready; nothing is dropped.
`include "sms_pdu_sender_number_extract_core_assert.svh"

module sms_pdu_sender_number_extract_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] pdu_byte
  input  logic       in_tuser,   // [0] pdu_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [5:0] out_char, [7:6] zero
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast   // out_last
);
  import smsne_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       free;
  logic       consume;
  res_grp_t   res;
  result_t    out_res;

  // Parse the held byte once the result buffer can take its whole group.
  assign consume   = in_vld_r && free;
  assign in_tready = !in_vld_r || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (consume) begin
      in_vld_r <= 1'b0;
    end
  end

  // Payload: capture on every accepted transaction.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  smsne_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (consume),
    .pdu_byte  (in_byte_r),
    .pdu_start (in_start_r),
    .res_o     (res)
  );

  smsne_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume),
    .res_i      (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {2'b00, out_res.ch};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  `SMSNE_AST_NXT(a_hold_blocked, in_vld_r && !free, in_vld_r && $stable(in_byte_r) && $stable(in_start_r), "held byte lost while blocked")
  `SMSNE_AST_IMP(a_char_nonlast, out_tvalid && out_tuser == KIND_CHAR, !out_tlast, "character result marked last")
  `SMSNE_AST_IMP(a_close_zero, out_tvalid && out_tuser != KIND_CHAR, out_tlast && out_tdata == 8'd0, "closing result with data")

endmodule
